[design/assert_macros.svh]
// Assertion macros included by the responder and forwarder design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/ier_pkg.sv]
// Package with constants and codes of the ICMP echo responder and forwarder.
package ier_pkg;
   localparam int DEF_MAX_FRAME_BYTES = 2048;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
   localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
   localparam int          MIN_FRAME      = 42;

   localparam logic [31:0] OWN_IP_RST   = 32'hC0A80102;
   localparam logic [31:0] PEER_IP_RST  = 32'hC0A80105;
   localparam logic [47:0] MAC_FAR_RST  = 48'd118884545540517;
   localparam logic [47:0] MAC_OWN_RST  = 48'd176156459264579;
   localparam logic [47:0] MAC_PEER_RST = 48'd109952948202986;

   localparam logic [2:0] REG_OWN_IP   = 3'd0;
   localparam logic [2:0] REG_PEER_IP  = 3'd1;
   localparam logic [2:0] REG_MAC_FAR  = 3'd2;
   localparam logic [2:0] REG_MAC_OWN  = 3'd3;
   localparam logic [2:0] REG_MAC_PEER = 3'd4;

   typedef enum logic [1:0] {
      ACT_DROP     = 2'd0,
      ACT_ECHO     = 2'd1,
      ACT_FWD_PEER = 2'd2,
      ACT_FWD_FAR  = 2'd3
   } action_type;

   // Ones-complement add of a 16-bit word with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction
endpackage

[design/ier_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module ier_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[design/icmp_echo_responder_forwarder.sv]
// Loads store frame bytes; after the last byte a judge state registers the verdict.
// A pull reads the store; the read state registers the edited byte and blocks requests.
// Loads without a result sustain one byte per cycle unless a held response stalls them.
// Checksums accumulate as bytes are loaded, so the verdict needs no pass over the store.
// Synchronous reset clears control state and loads the register defaults; the store is
// left as is and is only read at positions loaded for the current frame.
`include "assert_macros.svh"
module icmp_echo_responder_forwarder import ier_pkg::*; #(
   parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic        req_rx_port,
   input  logic [7:0]  req_data,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_verdict,
   output logic [1:0]  rsp_action,
   output logic        rsp_tx_port,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_final_byte,
   output logic        rsp_empty_res,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   localparam int AW = $clog2(MAX_FRAME_BYTES);
   localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME_BYTES);

   typedef enum logic [1:0] {ST_IDLE, ST_JUDGE, ST_READ} state_type;

   state_type   state_ff;
   logic [31:0] own_ip_ff, peer_ip_ff;
   logic [47:0] mac_far_ff, mac_own_ff, mac_peer_ff;
   logic [CW-1:0] count_ff, len_ff, read_pos_ff, rp_ff;
   logic        port_ff, pending_ff;
   logic [95:0] mac_ff, hdr_mac_ff;
   logic [15:0] eth_ff, ipl_ff, icmp_sum_ff, hdr_sum_ff, csum_ff;
   logic [7:0]  proto_ff, type_ff;
   logic [63:0] ip_ff;
   action_type  act_ff;
   logic        txp_ff;
   logic        rsp_valid_ff, rsp_is_verdict_ff, rsp_tx_port_ff;
   logic        rsp_final_ff, rsp_empty_ff;
   logic [1:0]  rsp_action_ff;
   logic [7:0]  rsp_byte_ff;

   logic        req_fire, load_fire, pull_fire;
   logic [CW-1:0] pos, count_in, len_now;
   logic [16:0] pos17;
   logic [15:0] icmp_add, hdr_add, icmp_sum_in, hdr_sum_in, word;
   logic [7:0]  ram_q, byte_sel;
   action_type  act_in;
   logic        txp_in;
   logic [3:0]  mi;
   logic [2:0]  ij;
   logic [63:0] ip_swp;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && !req_kind;
   assign pull_fire = req_fire && req_kind;
   assign pos       = count_ff;
   assign pos17     = 17'(pos);
   assign len_now   = (count_ff <= MAX_C) ? count_ff + CW'(1) : count_ff;

   ier_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES)) u_store (
      .clock (clock),
      .we    (load_fire && (count_ff < MAX_C)),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_data),
      .re    (pull_fire),
      .raddr (read_pos_ff[AW-1:0]),
      .rdata (ram_q)
   );

   // Running checksums; the reply type and both checksum fields count as zero.
   always_comb begin
      word = pos[0] ? {8'd0, req_data} : {req_data, 8'd0};
      icmp_add = 16'd0;
      hdr_add  = 16'd0;
      if ((pos17 >= 17'd34) && (pos17 < (17'(ipl_ff) + 17'd14)) &&
          (pos17 != 17'd34) && (pos17 != 17'd36) && (pos17 != 17'd37)) begin
         icmp_add = word;
      end
      if ((pos17 >= 17'd14) && (pos17 < 17'd34) &&
          (pos17 != 17'd24) && (pos17 != 17'd25)) begin
         hdr_add = word;
      end
      icmp_sum_in = oc_add((pos == '0) ? 16'd0 : icmp_sum_ff, icmp_add);
      hdr_sum_in  = oc_add((pos == '0) ? 16'd0 : hdr_sum_ff, hdr_add);
      count_in    = len_now;
   end

   always_comb begin
      act_in = ACT_DROP;
      txp_in = 1'b0;
      if ((len_ff <= MAX_C) && (len_ff >= CW'(MIN_FRAME)) && (eth_ff == ETHERTYPE_IPV4) &&
          (proto_ff == PROTO_ICMP) && (ipl_ff >= 16'd28) &&
          ((17'(ipl_ff) + 17'd14) <= 17'(len_ff))) begin
         if (ip_ff[31:0] == own_ip_ff) begin
            if (type_ff == ICMP_ECHO_REQ) begin
               act_in = ACT_ECHO;
               txp_in = 1'b1;
            end
         end else if ((ip_ff[31:0] == peer_ip_ff) && port_ff) begin
            act_in = ACT_FWD_PEER;
         end else if ((ip_ff[63:32] == peer_ip_ff) && !port_ff) begin
            act_in = ACT_FWD_FAR;
            txp_in = 1'b1;
         end
      end
   end

   // Edited header bytes replace the stored ones on the way out.
   always_comb begin
      mi       = 4'd11 - rp_ff[3:0];
      ij       = 3'd7 - 3'(rp_ff - CW'(26));
      ip_swp   = {ip_ff[31:0], ip_ff[63:32]};
      byte_sel = ram_q;
      if (rp_ff < CW'(12)) begin
         byte_sel = 8'(hdr_mac_ff >> {mi, 3'b000});
      end else if (act_ff == ACT_ECHO) begin
         if ((rp_ff >= CW'(26)) && (rp_ff < CW'(34))) begin
            byte_sel = 8'(ip_swp >> {ij, 3'b000});
         end else if (rp_ff == CW'(34)) begin
            byte_sel = ICMP_ECHO_REP;
         end else if (rp_ff == CW'(36)) begin
            byte_sel = csum_ff[15:8];
         end else if (rp_ff == CW'(37)) begin
            byte_sel = csum_ff[7:0];
         end
      end else if (rp_ff == CW'(24)) begin
         byte_sel = csum_ff[15:8];
      end else if (rp_ff == CW'(25)) begin
         byte_sel = csum_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         read_pos_ff  <= '0;
         own_ip_ff    <= OWN_IP_RST;
         peer_ip_ff   <= PEER_IP_RST;
         mac_far_ff   <= MAC_FAR_RST;
         mac_own_ff   <= MAC_OWN_RST;
         mac_peer_ff  <= MAC_PEER_RST;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_OWN_IP:   own_ip_ff   <= csr_wdata[31:0];
               REG_PEER_IP:  peer_ip_ff  <= csr_wdata[31:0];
               REG_MAC_FAR:  mac_far_ff  <= csr_wdata;
               REG_MAC_OWN:  mac_own_ff  <= csr_wdata;
               REG_MAC_PEER: mac_peer_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (load_fire) begin
                  pending_ff  <= 1'b0;
                  read_pos_ff <= '0;
                  if (pos == '0) port_ff <= req_rx_port;
                  if (pos < CW'(12)) mac_ff <= {mac_ff[87:0], req_data};
                  if ((pos == CW'(12)) || (pos == CW'(13))) eth_ff <= {eth_ff[7:0], req_data};
                  if ((pos == CW'(16)) || (pos == CW'(17))) ipl_ff <= {ipl_ff[7:0], req_data};
                  if (pos == CW'(23)) proto_ff <= req_data;
                  if ((pos >= CW'(26)) && (pos < CW'(34))) ip_ff <= {ip_ff[55:0], req_data};
                  if (pos == CW'(34)) type_ff <= req_data;
                  icmp_sum_ff <= icmp_sum_in;
                  hdr_sum_ff  <= hdr_sum_in;
                  if (req_last) begin
                     len_ff   <= len_now;
                     count_ff <= '0;
                     state_ff <= ST_JUDGE;
                  end else begin
                     count_ff <= count_in;
                  end
               end else if (pull_fire) begin
                  if (pending_ff) begin
                     rp_ff    <= read_pos_ff;
                     state_ff <= ST_READ;
                  end else begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_is_verdict_ff <= 1'b0;
                     rsp_action_ff     <= ACT_DROP;
                     rsp_tx_port_ff    <= 1'b0;
                     rsp_byte_ff       <= 8'd0;
                     rsp_final_ff      <= 1'b0;
                     rsp_empty_ff      <= 1'b1;
                  end
               end
            end
            ST_JUDGE: begin
               act_ff     <= act_in;
               txp_ff     <= txp_in;
               pending_ff <= (act_in != ACT_DROP);
               case (act_in)
                  ACT_ECHO: begin
                     hdr_mac_ff <= {mac_ff[47:0], mac_ff[95:48]};
                     csum_ff    <= ~icmp_sum_ff;
                  end
                  ACT_FWD_PEER: begin
                     hdr_mac_ff <= {mac_peer_ff, mac_own_ff};
                     csum_ff    <= ~hdr_sum_ff;
                  end
                  default: begin
                     hdr_mac_ff <= {mac_far_ff, mac_own_ff};
                     csum_ff    <= ~hdr_sum_ff;
                  end
               endcase
               rsp_valid_ff      <= 1'b1;
               rsp_is_verdict_ff <= 1'b1;
               rsp_action_ff     <= act_in;
               rsp_tx_port_ff    <= txp_in;
               rsp_byte_ff       <= 8'd0;
               rsp_final_ff      <= 1'b0;
               rsp_empty_ff      <= 1'b0;
               state_ff          <= ST_IDLE;
            end
            ST_READ: begin
               rsp_valid_ff      <= 1'b1;
               rsp_is_verdict_ff <= 1'b0;
               rsp_action_ff     <= act_ff;
               rsp_tx_port_ff    <= txp_ff;
               rsp_byte_ff       <= byte_sel;
               rsp_empty_ff      <= 1'b0;
               rsp_final_ff      <= (rp_ff + CW'(1) == len_ff);
               if (rp_ff + CW'(1) >= len_ff) begin
                  pending_ff  <= 1'b0;
                  read_pos_ff <= '0;
               end else begin
                  read_pos_ff <= rp_ff + CW'(1);
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_verdict = rsp_is_verdict_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_tx_port    = rsp_tx_port_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_final_byte = rsp_final_ff;
   assign rsp_empty_res  = rsp_empty_ff;

   `ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid_ff)
   `ASSERT_RST(a_rsp_holds, clock, reset, rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
   `ASSERT_RST(a_pending_in_frame, clock, reset, pending_ff |-> (read_pos_ff < len_ff))
   `ASSERT_RST(a_verdict_not_empty, clock, reset, rsp_valid_ff && rsp_is_verdict_ff |-> !rsp_empty_ff)
   `ASSERT_RST(a_read_after_pull, clock, reset, (state_ff == ST_READ) |-> $past(pull_fire))
endmodule
